// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SRSDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication checked outside reset
`define SRSDL_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/srsdl_pkg.sv =====
// shared types and constants for the row strength drop and lump unit
`default_nettype none

package srsdl_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_THRESHOLD = 1'b0,
    CFG_LUMP_ENABLE    = 1'b1
  } cfg_reg_t;

  localparam logic [THR_W-1:0] THR_RESET  = 16'd3277;
  localparam logic             LUMP_RESET = 1'b1;

  // classification of one entry, front to back
  typedef struct packed {
    logic drop;
    logic diag;
    logic last;
  } cls_t;

endpackage

`default_nettype wire

// ===== sv/srsdl_queue.sv =====
// small fifo between the classify front and the row accumulate back
`default_nettype none

module srsdl_queue #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 push_data,
  input  logic                             pop,
  output logic                             pop_valid,
  output logic [WIDTH-1:0]                 pop_data,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);

`include "assert_macros.svh"

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // occupancy update
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

  `SRSDL_IMPLY(a_no_overflow, push && !pop, count_r < CNT_W'(DEPTH), "queue push while full")
  `SRSDL_IMPLY(a_no_underflow, pop, count_r != '0, "queue pop while empty")

endmodule

`default_nettype wire

// ===== sv/srsdl_front.sv =====
// front end: accepts entries and runs the widened strength test
`default_nettype none

module srsdl_front
  import srsdl_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [INDEX_BITS-1:0]    in_row_index,
  input  logic [INDEX_BITS-1:0]    in_col_index,
  input  logic [DATA_W-1:0]        in_entry_value,
  input  logic [DATA_W-1:0]        in_row_diag,
  input  logic [DATA_W-1:0]        in_col_diag,
  input  logic                     in_row_last,
  input  logic [THR_W-1:0]         drop_threshold,
  input  logic [QCNT_W-1:0]        q_count,
  output logic                     push,
  output cls_t                     push_cls,
  output logic [INDEX_BITS-1:0]    push_col,
  output logic [DATA_W-1:0]        push_val
);

`include "assert_macros.svh"

  localparam int unsigned OCC_W = QCNT_W + 1;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // magnitude of a signed word, full range fits unsigned
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  logic                  accept;
  logic [OCC_W-1:0]      occ;

  // stage 1: registered inputs
  logic                  s1_valid_r, s1_diag_r, s1_last_r;
  logic [INDEX_BITS-1:0] s1_col_r;
  logic [DATA_W-1:0]     s1_val_r, s1_rdiag_r, s1_cdiag_r;

  // stage 2: squares and diagonal product
  logic                  s2_valid_r, s2_diag_r, s2_last_r;
  logic [INDEX_BITS-1:0] s2_col_r;
  logic [DATA_W-1:0]     s2_val_r;
  logic [PROD_W-1:0]     s2_v2_r, s2_p_r;
  logic [DATA_W-1:0]     s2_e_r;
  logic [DATA_W-1:0]     mv, mi, mj;
  logic [PROD_W-1:0]     v2_w, p_w;
  logic [DATA_W-1:0]     e_w;

  // stage 3: partial products of the threshold side
  logic                  s3_valid_r, s3_diag_r, s3_last_r;
  logic [INDEX_BITS-1:0] s3_col_r;
  logic [DATA_W-1:0]     s3_val_r;
  logic [PROD_W-1:0]     s3_v2_r, s3_pl_r, s3_ph_r;
  logic [PROD_W-1:0]     pl_w, ph_w;

  // final compare
  logic [PROD_W:0]       rhs_hi;
  logic                  weak_hit;

  // credit check against queue room
  assign occ = OCC_W'(q_count) + OCC_W'(s1_valid_r) + OCC_W'(s2_valid_r)
             + OCC_W'(s3_valid_r);
  assign in_stall = (occ >= OCC_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  assign mv   = mag(s1_val_r);
  assign mi   = mag(s1_rdiag_r);
  assign mj   = mag(s1_cdiag_r);
  assign v2_w = mv * mv;
  assign p_w  = mi * mj;
  assign e_w  = drop_threshold * drop_threshold;

  assign pl_w = s2_p_r[DATA_W-1:0] * s2_e_r;
  assign ph_w = s2_p_r[PROD_W-1:DATA_W] * s2_e_r;

  // v^2 * 2^32 <= p * e reduces to v^2 <= (p * e) >> 32
  assign rhs_hi   = {1'b0, s3_ph_r} + {{(DATA_W + 1){1'b0}}, s3_pl_r[PROD_W-1:DATA_W]};
  assign weak_hit = ({1'b0, s3_v2_r} <= rhs_hi);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_diag_r  <= (in_row_index == in_col_index);
      s1_last_r  <= in_row_last;
      s1_col_r   <= in_col_index;
      s1_val_r   <= in_entry_value;
      s1_rdiag_r <= in_row_diag;
      s1_cdiag_r <= in_col_diag;
    end
    s2_diag_r <= s1_diag_r;
    s2_last_r <= s1_last_r;
    s2_col_r  <= s1_col_r;
    s2_val_r  <= s1_val_r;
    s2_v2_r   <= v2_w;
    s2_p_r    <= p_w;
    s2_e_r    <= e_w;
    s3_diag_r <= s2_diag_r;
    s3_last_r <= s2_last_r;
    s3_col_r  <= s2_col_r;
    s3_val_r  <= s2_val_r;
    s3_v2_r   <= s2_v2_r;
    s3_pl_r   <= pl_w;
    s3_ph_r   <= ph_w;
  end

  // classified entry into the queue, the diagonal is always kept
  assign push          = s3_valid_r;
  assign push_cls.drop = weak_hit && !s3_diag_r;
  assign push_cls.diag = s3_diag_r;
  assign push_cls.last = s3_last_r;
  assign push_col      = s3_col_r;
  assign push_val      = s3_val_r;

  `SRSDL_ASSERT(a_credit_bound, occ <= OCC_W'(QUEUE_DEPTH), "entries in flight exceed queue room")

endmodule

`default_nettype wire

// ===== sv/srsdl_back.sv =====
// back end: row accumulation, lumping and the output register
`default_nettype none

module srsdl_back
  import srsdl_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = 20,
  parameter int unsigned ROW_LEN_MAX = 64
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      lump_enable,
  input  logic                                      q_valid,
  input  cls_t                                      q_cls,
  input  logic [INDEX_BITS-1:0]                     q_col,
  input  logic [DATA_W-1:0]                         q_val,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_entry_dropped,
  output logic [INDEX_BITS-1:0]                     out_out_col,
  output logic [DATA_W-1:0]                         out_out_value,
  output logic                                      out_row_done,
  output logic                                      out_diag_found,
  output logic [$clog2(ROW_LEN_MAX + 1)-1:0]        out_row_kept_count,
  output logic [((ROW_LEN_MAX > 1) ? $clog2(ROW_LEN_MAX) : 1)-1:0] out_diag_offset,
  output logic [DATA_W-1:0]                         out_diag_lumped_value,
  output logic [TOTAL_W-1:0]                        out_total_kept
);

`include "assert_macros.svh"

  localparam int unsigned KC_W  = $clog2(ROW_LEN_MAX + 1);
  localparam int unsigned POS_W = (ROW_LEN_MAX > 1) ? $clog2(ROW_LEN_MAX) : 1;
  localparam int unsigned EXT_W = SUM_W + 1 - DATA_W;
  localparam logic [KC_W-1:0]   KC_MAX  = KC_W'(ROW_LEN_MAX);
  localparam logic [POS_W-1:0]  POS_MAX = POS_W'(ROW_LEN_MAX - 1);
  localparam logic [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  logic adv;

  // open row state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [KC_W-1:0]   kc_r, kc_nxt;
  logic [SUM_W-1:0]  dsum_r, dsum_nxt;
  logic              seen_r, seen_nxt;
  logic [POS_W-1:0]  dpos_r, dpos_nxt;
  logic [DATA_W-1:0] dval_r, dval_nxt;
  logic [SUM_W:0]    dsum_add;

  // entry stage with row snapshot
  logic                  a_valid_r;
  logic                  a_drop_r, a_last_r, a_seen_r;
  logic [INDEX_BITS-1:0] a_col_r;
  logic [DATA_W-1:0]     a_val_r, a_dval_r;
  logic [KC_W-1:0]       a_kc_r;
  logic [POS_W-1:0]      a_dpos_r;
  logic [SUM_W-1:0]      a_dsum_r;

  // summary arithmetic
  logic [SUM_W:0]        lump_sum;
  logic                  lump_fits;
  logic [DATA_W-1:0]     lump_sat, diag_value;
  logic [TOTAL_W:0]      total_add;
  logic [TOTAL_W-1:0]    kept_total_r, kept_total_nxt;

  // output register
  logic                  out_valid_r, out_dropped_r, out_done_r, out_found_r;
  logic [INDEX_BITS-1:0] out_col_r;
  logic [DATA_W-1:0]     out_value_r, out_lumped_r;
  logic [KC_W-1:0]       out_kc_r;
  logic [POS_W-1:0]      out_offset_r;
  logic [TOTAL_W-1:0]    out_total_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && q_valid;

  // row accumulation for the entry leaving the queue
  assign dsum_add = {dsum_r[SUM_W-1], dsum_r} + {{EXT_W{q_val[DATA_W-1]}}, q_val};

  always_comb begin
    pos_nxt  = pos_r;
    kc_nxt   = kc_r;
    dsum_nxt = dsum_r;
    seen_nxt = seen_r;
    dpos_nxt = dpos_r;
    dval_nxt = dval_r;
    if (q_cls.drop) begin
      if (dsum_add[SUM_W] != dsum_add[SUM_W-1]) begin
        dsum_nxt = dsum_add[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        dsum_nxt = dsum_add[SUM_W-1:0];
      end
    end else begin
      if (kc_r != KC_MAX) begin
        kc_nxt = kc_r + KC_W'(1);
      end
      if (q_cls.diag) begin
        seen_nxt = 1'b1;
        dpos_nxt = pos_r;
        dval_nxt = q_val;
      end
    end
    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // row state registers, cleared after the last entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kc_r   <= '0;
      dsum_r <= '0;
      seen_r <= 1'b0;
      dpos_r <= '0;
      dval_r <= '0;
    end else if (pop) begin
      if (q_cls.last) begin
        pos_r  <= '0;
        kc_r   <= '0;
        dsum_r <= '0;
        seen_r <= 1'b0;
        dpos_r <= '0;
        dval_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        kc_r   <= kc_nxt;
        dsum_r <= dsum_nxt;
        seen_r <= seen_nxt;
        dpos_r <= dpos_nxt;
        dval_r <= dval_nxt;
      end
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_drop_r <= q_cls.drop;
      a_last_r <= q_cls.last;
      a_col_r  <= q_cls.drop ? {INDEX_BITS{1'b1}} : q_col;
      a_val_r  <= q_cls.drop ? '0 : q_val;
      a_seen_r <= seen_nxt;
      a_kc_r   <= kc_nxt;
      a_dpos_r <= dpos_nxt;
      a_dval_r <= dval_nxt;
      a_dsum_r <= dsum_nxt;
    end
  end

  // diagonal plus dropped sum, saturated to the value range
  assign lump_sum  = {{EXT_W{a_dval_r[DATA_W-1]}}, a_dval_r} + {a_dsum_r[SUM_W-1], a_dsum_r};
  assign lump_fits = (lump_sum[SUM_W:DATA_W-1] == '0) || (lump_sum[SUM_W:DATA_W-1] == '1);
  assign lump_sat  = lump_fits ? lump_sum[DATA_W-1:0] : (lump_sum[SUM_W] ? VAL_MIN : VAL_MAX);

  always_comb begin
    priority if (!a_seen_r) begin
      diag_value = '0;
    end else if (lump_enable) begin
      diag_value = lump_sat;
    end else begin
      diag_value = a_dval_r;
    end
  end

  // running kept total over rows with a diagonal, saturating
  assign total_add      = {1'b0, kept_total_r} + (TOTAL_W + 1)'(a_kc_r);
  assign kept_total_nxt = (a_last_r && a_seen_r)
                        ? (total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0])
                        : kept_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      kept_total_r <= '0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
      if (a_valid_r) begin
        kept_total_r <= kept_total_nxt;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_dropped_r <= a_drop_r;
      out_col_r     <= a_col_r;
      out_value_r   <= a_val_r;
      out_done_r    <= a_last_r;
      out_found_r   <= a_last_r && a_seen_r;
      out_kc_r      <= a_last_r ? a_kc_r : '0;
      out_offset_r  <= (a_last_r && a_seen_r) ? a_dpos_r : '0;
      out_lumped_r  <= a_last_r ? diag_value : '0;
      out_total_r   <= kept_total_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_entry_dropped     = out_dropped_r;
  assign out_out_col           = out_col_r;
  assign out_out_value         = out_value_r;
  assign out_row_done          = out_done_r;
  assign out_diag_found        = out_found_r;
  assign out_row_kept_count    = out_kc_r;
  assign out_diag_offset       = out_offset_r;
  assign out_diag_lumped_value = out_lumped_r;
  assign out_total_kept        = out_total_r;

  `SRSDL_ASSERT(a_row_clear, (pop && q_cls.last) |=> (kc_r == '0 && !seen_r && dsum_r == '0), "row state not cleared after last entry")
  `SRSDL_IMPLY(a_drop_zero, out_valid_r && out_dropped_r, out_value_r == '0 && out_col_r == '1, "dropped entry carries data")
  `SRSDL_IMPLY(a_summary_idle, out_valid_r && !out_done_r, !out_found_r && out_kc_r == '0 && out_lumped_r == '0, "summary fields set outside row end")

endmodule

`default_nettype wire

// ===== sv/sparse_row_strength_drop_lump_unit.sv =====
// Path: an entry passes the three strength test stages, the queue, the entry stage and the output register.
// Throughput: one entry per cycle; the three-stage strength test feeds an eight-entry
// queue, and entry acceptance stops when queue room is used up by items in flight.
// Row state updates once per entry at the queue output.
// Reset: synchronous active-low; clears row state, running total, queue and valids,
// and loads drop_threshold with 3277 and lump_enable with 1.
`default_nettype none

module sparse_row_strength_drop_lump_unit
  import srsdl_pkg::*;
#(
  parameter int unsigned ROW_LEN_MAX = 64,
  parameter int unsigned INDEX_BITS  = 20
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_wdata,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [INDEX_BITS-1:0]                     in_row_index,
  input  logic [INDEX_BITS-1:0]                     in_col_index,
  input  logic [DATA_W-1:0]                         in_entry_value,
  input  logic [DATA_W-1:0]                         in_row_diag,
  input  logic [DATA_W-1:0]                         in_col_diag,
  input  logic                                      in_row_last,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_entry_dropped,
  output logic [INDEX_BITS-1:0]                     out_out_col,
  output logic [DATA_W-1:0]                         out_out_value,
  output logic                                      out_row_done,
  output logic                                      out_diag_found,
  output logic [$clog2(ROW_LEN_MAX + 1)-1:0]        out_row_kept_count,
  output logic [((ROW_LEN_MAX > 1) ? $clog2(ROW_LEN_MAX) : 1)-1:0] out_diag_offset,
  output logic [DATA_W-1:0]                         out_diag_lumped_value,
  output logic [TOTAL_W-1:0]                        out_total_kept
);

  localparam int unsigned Q_W = $bits(cls_t) + INDEX_BITS + DATA_W;

  logic [THR_W-1:0]      thr_r;
  logic                  lump_r;

  logic                  push, pop, q_valid;
  cls_t                  push_cls, q_cls;
  logic [INDEX_BITS-1:0] push_col, q_col;
  logic [DATA_W-1:0]     push_val, q_val;
  logic [Q_W-1:0]        q_wdata, q_rdata;
  logic [QCNT_W-1:0]     q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      lump_r <= LUMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DROP_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_LUMP_ENABLE:    lump_r <= cfg_wdata[0];
        default:            thr_r  <= thr_r;
      endcase
    end
  end

  // classify front
  srsdl_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .in_row_diag    (in_row_diag),
    .in_col_diag    (in_col_diag),
    .in_row_last    (in_row_last),
    .drop_threshold (thr_r),
    .q_count        (q_count),
    .push           (push),
    .push_cls       (push_cls),
    .push_col       (push_col),
    .push_val       (push_val)
  );

  // queue between front and back
  assign q_wdata = {push_cls, push_col, push_val};
  assign {q_cls, q_col, q_val} = q_rdata;

  srsdl_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_wdata),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata),
    .count     (q_count)
  );

  // row accumulate back
  srsdl_back #(
    .INDEX_BITS  (INDEX_BITS),
    .ROW_LEN_MAX (ROW_LEN_MAX)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .lump_enable           (lump_r),
    .q_valid               (q_valid),
    .q_cls                 (q_cls),
    .q_col                 (q_col),
    .q_val                 (q_val),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_entry_dropped     (out_entry_dropped),
    .out_out_col           (out_out_col),
    .out_out_value         (out_out_value),
    .out_row_done          (out_row_done),
    .out_diag_found        (out_diag_found),
    .out_row_kept_count    (out_row_kept_count),
    .out_diag_offset       (out_diag_offset),
    .out_diag_lumped_value (out_diag_lumped_value),
    .out_total_kept        (out_total_kept)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// sparse row strength drop and lump unit testbench: directed and random rows checked against a predictor
`timescale 1ns / 1ps

module tb;
  import srsdl_pkg::*;

  localparam int     IDLE_LIMIT   = 4000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_TAIL   = 12;
  localparam int     NUM_PHASES   = 7;
  localparam int     PHASE_ITEMS  = 100;
  localparam int     LONG_PHASE   = 2;
  localparam int     HOLD_PHASE   = 3;
  localparam int     PAUSE_PHASE  = 4;
  localparam longint DROP_SUM_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam longint DROP_SUM_MIN = -DROP_SUM_MAX - 1;
  localparam longint LUMP_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint LUMP_MIN     = -LUMP_MAX - 1;
  localparam longint TOTAL_CAP    = 64'sh0000_0000_FFFF_FFFF;
  localparam logic [19:0] NO_COL  = 20'hFFFFF;

  typedef struct packed {
    logic [19:0] row;
    logic [19:0] col;
    logic [31:0] value;
    logic [31:0] row_diag;
    logic [31:0] col_diag;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic        dropped;
    logic [19:0] col;
    logic [31:0] value;
    logic        row_done;
    logic        diag_found;
    logic [6:0]  kept_count;
    logic [5:0]  diag_offset;
    logic [31:0] lumped;
    logic [31:0] total;
  } result_t;

  // row filter predictor and the queue of results it expects
  class strength_filter_book;
    logic [15:0] eps_q16;
    logic        lump_on;
    int          position;
    int          kept;
    int          diag_pos;
    bit          diag_hit;
    longint      drop_sum;
    longint      diag_val;
    longint      kept_sum;
    result_t     pending_results[$];
    int unsigned failures;

    function new();
      eps_q16  = THR_RESET;
      lump_on  = LUMP_RESET;
      kept_sum = 0;
      failures = 0;
      clear_row();
    endfunction

    function void clear_row();
      position = 0;
      kept     = 0;
      diag_pos = 0;
      diag_hit = 0;
      drop_sum = 0;
      diag_val = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        CFG_DROP_THRESHOLD: eps_q16 = val;
        CFG_LUMP_ENABLE:    lump_on = val[0];
        default: ;
      endcase
    endfunction

    static function logic [63:0] magnitude(logic [31:0] v);
      longint w;
      w = {{32{v[31]}}, v};
      return (w < 0) ? -w : w;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // strength test, drop accounting and row summary for one entry
    function result_t filter_entry(entry_t e);
      result_t      r;
      logic [63:0]  mv;
      logic [31:0]  eps_sq;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic         is_diag;
      longint       v;
      longint       lumped;
      r       = '0;
      is_diag = (e.row == e.col);
      v       = {{32{e.value[31]}}, e.value};
      mv      = magnitude(e.value);
      eps_sq  = eps_q16 * eps_q16;
      // a^2 scaled by 2^32 against eps^2 * |aii| * |ajj|, exact
      lhs = {32'd0, mv * mv, 32'd0};
      rhs = {64'd0, magnitude(e.row_diag) * magnitude(e.col_diag)} * {96'd0, eps_sq};
      if (is_diag || lhs > rhs) begin
        r.col   = e.col;
        r.value = e.value;
        if (kept < 64) kept++;
        if (is_diag) begin
          diag_hit = 1;
          diag_pos = position;
          diag_val = v;
        end
      end else begin
        drop_sum = drop_sum + v;
        if (drop_sum > DROP_SUM_MAX) drop_sum = DROP_SUM_MAX;
        if (drop_sum < DROP_SUM_MIN) drop_sum = DROP_SUM_MIN;
        r.dropped = 1;
        r.col     = NO_COL;
      end
      if (position < 63) position++;
      // row summary includes the closing entry
      if (e.last) begin
        r.row_done   = 1;
        r.diag_found = diag_hit;
        r.kept_count = kept[6:0];
        if (diag_hit) begin
          lumped = diag_val;
          if (lump_on) begin
            lumped = lumped + drop_sum;
            if (lumped > LUMP_MAX) lumped = LUMP_MAX;
            if (lumped < LUMP_MIN) lumped = LUMP_MIN;
          end
          r.diag_offset = diag_pos[5:0];
          r.lumped      = lumped[31:0];
          kept_sum      = kept_sum + kept;
          if (kept_sum > TOTAL_CAP) kept_sum = TOTAL_CAP;
        end
        clear_row();
      end
      r.total = kept_sum[31:0];
      return r;
    endfunction

    function void note_entry(entry_t e);
      pending_results.push_back(filter_entry(e));
    endfunction

    function void match_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no entry outstanding");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      match_field("entry_dropped", 32'(want.dropped), 32'(got.dropped));
      match_field("out_col", 32'(want.col), 32'(got.col));
      match_field("out_value", want.value, got.value);
      match_field("row_done", 32'(want.row_done), 32'(got.row_done));
      match_field("diag_found", 32'(want.diag_found), 32'(got.diag_found));
      match_field("row_kept_count", 32'(want.kept_count), 32'(got.kept_count));
      match_field("diag_offset", 32'(want.diag_offset), 32'(got.diag_offset));
      match_field("diag_lumped_value", want.lumped, got.lumped);
      match_field("total_kept", want.total, got.total);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [19:0]          in_row_index;
  logic [19:0]          in_col_index;
  logic [31:0]          in_entry_value;
  logic [31:0]          in_row_diag;
  logic [31:0]          in_col_diag;
  logic                 in_row_last;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_entry_dropped;
  logic [19:0]          out_out_col;
  logic [31:0]          out_out_value;
  logic                 out_row_done;
  logic                 out_diag_found;
  logic [6:0]           out_row_kept_count;
  logic [5:0]           out_diag_offset;
  logic [31:0]          out_diag_lumped_value;
  logic [31:0]          out_total_kept;

  strength_filter_book book;
  int                  burst_left = 0;
  int                  hold_req = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  seg_left = 0;
  int                  stall_pct = 0;
  int                  idle_cycles = 0;

  sparse_row_strength_drop_lump_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_row_index          (in_row_index),
    .in_col_index          (in_col_index),
    .in_entry_value        (in_entry_value),
    .in_row_diag           (in_row_diag),
    .in_col_diag           (in_col_diag),
    .in_row_last           (in_row_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_entry_dropped     (out_entry_dropped),
    .out_out_col           (out_out_col),
    .out_out_value         (out_out_value),
    .out_row_done          (out_row_done),
    .out_diag_found        (out_diag_found),
    .out_row_kept_count    (out_row_kept_count),
    .out_diag_offset       (out_diag_offset),
    .out_diag_lumped_value (out_diag_lumped_value),
    .out_total_kept        (out_total_kept)
  );

  always #2 clk = ~clk;

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result transfers go to the checker
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.dropped    = out_entry_dropped;
      got.col        = out_out_col;
      got.value      = out_out_value;
      got.row_done   = out_row_done;
      got.diag_found = out_diag_found;
      got.kept_count = out_row_kept_count;
      got.diag_offset = out_diag_offset;
      got.lumped     = out_diag_lumped_value;
      got.total      = out_total_kept;
      book.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic entry_t make_entry(logic [19:0] row, logic [19:0] col, logic [31:0] value,
                                        logic [31:0] rd, logic [31:0] cd, logic last);
    entry_t e;
    e.row      = row;
    e.col      = col;
    e.value    = value;
    e.row_diag = rd;
    e.col_diag = cd;
    e.last     = last;
    return e;
  endfunction

  // signed Q16.16 with a random magnitude scale and some extremes
  function automatic logic [31:0] rand_q16(int max_shift);
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h0;
      default: begin
        v = $urandom >> $urandom_range(0, max_shift);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // one entry transfer, with bursts and random gaps on the sender side
  task automatic send_entry(input entry_t e);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_row_index   <= e.row;
    in_col_index   <= e.col;
    in_entry_value <= e.value;
    in_row_diag    <= e.row_diag;
    in_col_diag    <= e.col_diag;
    in_row_last    <= e.last;
    do @(posedge clk); while (in_stall);
    book.note_entry(e);
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // one register write, then cfg_we goes low and the bus is quiet before the task returns
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_reg(idx, val);
    @(posedge clk);
  endtask

  // well-formed row: random content, usually holding its diagonal
  task automatic send_row(output int count);
    logic [19:0] r;
    int          len;
    int          dpos;
    int          dup;
    entry_t      e;
    r    = 20'($urandom);
    len  = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
    dpos = ($urandom_range(0, 6) == 0) ? -1 : $urandom_range(0, len - 1);
    dup  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      e = make_entry(r, 20'($urandom), rand_q16(31), rand_q16(24), rand_q16(24), k == len - 1);
      if (k == dpos || k == dup) e.col = r;
      send_entry(e);
    end
    count = len;
  endtask

  // row past the length limit: kept count and dropped sum both saturate
  task automatic send_long_row();
    logic [19:0] r;
    r = 20'($urandom);
    for (int k = 0; k < 340; k++) begin
      if (k < 80)
        send_entry(make_entry(r, r ^ 20'(k + 1), 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                              1'b0));
      else if (k == 100)
        send_entry(make_entry(r, r, 32'h4000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
      else
        send_entry(make_entry(r, r ^ 20'h80000, 32'h8001_0000, 32'h8000_0000, 32'h8000_0000,
                              k == 339));
    end
  endtask

  initial begin
    logic [15:0] thr_list [NUM_PHASES];
    logic        lump_list [NUM_PHASES];
    int          sent;
    int          n;
    bit          hold_done;
    bit          pause_done;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_DROP_THRESHOLD;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_row_index   <= '0;
    in_col_index   <= '0;
    in_entry_value <= '0;
    in_row_diag    <= '0;
    in_col_diag    <= '0;
    in_row_last    <= 1'b0;
    book = new();
    hold_done  = 0;
    pause_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, repeated diagonal, zero entry, no-diagonal row
    send_entry(make_entry(20'h0, 20'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_entry(make_entry(20'hFFFFF, 20'h0, 32'h1, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_entry(make_entry(20'hFFFFF, 20'hFFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          1'b0));
    send_entry(make_entry(20'hFFFFF, 20'h12345, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
                          1'b0));
    send_entry(make_entry(20'hFFFFF, 20'hFFFFF, 32'h0000_1000, 32'h0, 32'h0, 1'b0));
    send_entry(make_entry(20'hFFFFF, 20'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    send_entry(make_entry(20'hFFFFF, 20'h7, 32'h1, 32'h0, 32'h0, 1'b1));
    // lumped value saturates high, then low
    send_entry(make_entry(20'h8, 20'h8, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_entry(make_entry(20'h8, 20'h1, 32'h0600_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_entry(make_entry(20'h8, 20'h1, 32'h0600_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_entry(make_entry(20'h8, 20'h2, 32'h0600_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_entry(make_entry(20'h9, 20'h9, 32'h8001_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_entry(make_entry(20'h9, 20'h3, 32'hFA00_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_entry(make_entry(20'h9, 20'h4, 32'hFA00_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    // row index changes without a row end
    send_entry(make_entry(20'h3, 20'h5, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
    send_entry(make_entry(20'h4, 20'h6, 32'h0000_0010, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    drain();

    // eps one half, no lumping: exact equality is weak
    write_reg(CFG_DROP_THRESHOLD, 16'h8000);
    write_reg(CFG_LUMP_ENABLE, 16'h0);
    send_entry(make_entry(20'hA, 20'hA, 32'h0005_0000, 32'h0002_0000, 32'h0002_0000, 1'b0));
    send_entry(make_entry(20'hA, 20'hB, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 1'b0));
    send_entry(make_entry(20'hA, 20'hC, 32'h0001_0001, 32'h0002_0000, 32'h0002_0000, 1'b0));
    send_entry(make_entry(20'hA, 20'hD, 32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000, 1'b1));
    drain();

    // zero eps: only zero values are weak
    write_reg(CFG_DROP_THRESHOLD, 16'h0);
    write_reg(CFG_LUMP_ENABLE, 16'h1);
    send_entry(make_entry(20'hB, 20'hE, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_entry(make_entry(20'hB, 20'hF, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_entry(make_entry(20'hB, 20'hB, 32'h0, 32'h0, 32'h0, 1'b1));

    // random phases over several settings
    thr_list  = '{16'd3277, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd3277};
    lump_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    thr_list[5]  = 16'($urandom_range(0, 65535));
    lump_list[5] = 1'($urandom_range(0, 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_DROP_THRESHOLD, thr_list[p]);
      write_reg(CFG_LUMP_ENABLE, {15'd0, lump_list[p]});
      if (p == LONG_PHASE) send_long_row();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == HOLD_PHASE && !hold_done && sent >= 20) begin
          hold_req  <= hold_req + 1;
          hold_done = 1;
        end
        if (p == PAUSE_PHASE && !pause_done && sent >= 70) begin
          drain();
          pause_done = 1;
        end
        // occasional noise entry with arbitrary fields
        if ($urandom_range(0, 9) == 0) begin
          send_entry(make_entry(20'($urandom),
                                ($urandom_range(0, 4) == 0) ? in_row_index : 20'($urandom),
                                $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0));
          sent++;
        end else begin
          send_row(n);
          sent += n;
        end
      end
    end

    drain();
    if (book.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
